// ===== hw/rtl/upt_pkg.sv =====
// ----------------------------------------------------------------------------
// Upload progress tracker package
// Widths, request codes and the word types shared by the tracker modules.
// ----------------------------------------------------------------------------
package upt_pkg;

  // Width of the generation tag register.
  localparam int GEN_WIDTH   = 32;
  // Width of the total, queued and acknowledged byte counters.
  localparam int COUNT_WIDTH = 32;
  // Width of the ports and of the chunk size register.
  localparam int PORT_WIDTH  = 32;
  // Width used for compares that mix port and counter widths.
  localparam int CALC_WIDTH  = 64;

  // Reset value of the chunk size limit.
  localparam logic [PORT_WIDTH-1:0] MAX_CHUNK_RESET = PORT_WIDTH'(4096);

  // Request codes; codes five to seven act as a query.
  localparam logic [2:0] REQ_BEGIN      = 3'd0;
  localparam logic [2:0] REQ_INVALIDATE = 3'd1;
  localparam logic [2:0] REQ_RECORD     = 3'd2;
  localparam logic [2:0] REQ_ACK        = 3'd3;
  localparam logic [2:0] REQ_QUERY      = 3'd4;

  // One request word.
  typedef struct packed {
    logic [2:0]            req_type;
    logic [PORT_WIDTH-1:0] generation_tag;
    logic [PORT_WIDTH-1:0] total_bytes;
    logic [PORT_WIDTH-1:0] requested_bytes;
    logic [PORT_WIDTH-1:0] accepted_bytes;
    logic [PORT_WIDTH-1:0] ack_bytes;
  } req_item_t;

  // One response word.
  typedef struct packed {
    logic                  op_ok;
    logic [PORT_WIDTH-1:0] current_tag;
    logic                  tag_current;
    logic [PORT_WIDTH-1:0] chunk_size;
    logic                  transfer_done;
  } rsp_item_t;

endpackage

// ===== hw/rtl/upt_if.sv =====
// ----------------------------------------------------------------------------
// Upload progress tracker channels
// Valid/ready channels for requests, responses and the chunk size register.
// ----------------------------------------------------------------------------

// Request channel.
interface upt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] generation_tag;
  logic [31:0] total_bytes;
  logic [31:0] requested_bytes;
  logic [31:0] accepted_bytes;
  logic [31:0] ack_bytes;

  modport source (
    output valid, req_type, generation_tag, total_bytes, requested_bytes,
           accepted_bytes, ack_bytes,
    input  ready
  );
  modport sink (
    input  valid, req_type, generation_tag, total_bytes, requested_bytes,
           accepted_bytes, ack_bytes,
    output ready
  );
endinterface

// Response channel.
interface upt_rsp_if;
  logic        valid;
  logic        ready;
  logic        op_ok;
  logic [31:0] current_tag;
  logic        tag_current;
  logic [31:0] chunk_size;
  logic        transfer_done;

  modport source (
    output valid, op_ok, current_tag, tag_current, chunk_size, transfer_done,
    input  ready
  );
  modport sink (
    input  valid, op_ok, current_tag, tag_current, chunk_size, transfer_done,
    output ready
  );
endinterface

// Chunk size register write channel.
interface upt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/upt_core.sv =====
// ----------------------------------------------------------------------------
// Upload progress tracker core
// Holds the tag and byte counters and forms the response for one request.
// ----------------------------------------------------------------------------
module upt_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  upt_pkg::req_item_t item,
  input  logic [31:0]        max_chunk,
  output upt_pkg::rsp_item_t result
);
  import upt_pkg::*;

  localparam logic [CALC_WIDTH-1:0] CNT_MAX = CALC_WIDTH'({COUNT_WIDTH{1'b1}});

  logic [GEN_WIDTH-1:0]   gen_counter;
  logic [COUNT_WIDTH-1:0] total_count;
  logic [COUNT_WIDTH-1:0] queued_count;
  logic [COUNT_WIDTH-1:0] acked_count;
  logic                   upload_active;

  logic [GEN_WIDTH-1:0]   gen_counter_next;
  logic [COUNT_WIDTH-1:0] total_count_next;
  logic [COUNT_WIDTH-1:0] queued_count_next;
  logic [COUNT_WIDTH-1:0] acked_count_next;
  logic                   upload_active_next;

  logic [GEN_WIDTH-1:0]   gen_step;
  logic [CALC_WIDTH-1:0]  tag_wide;
  logic [CALC_WIDTH-1:0]  total_wide;
  logic [CALC_WIDTH-1:0]  unqueued_wide;
  logic [CALC_WIDTH-1:0]  unacked_wide;
  logic [CALC_WIDTH-1:0]  left_wide;
  logic                   cur_before;
  logic                   cur_after;
  logic                   op_ok;

  // Tag advance wraps from all ones to one, never to zero.
  assign gen_step = (gen_counter == {GEN_WIDTH{1'b1}}) ? GEN_WIDTH'(1)
                                                       : gen_counter + GEN_WIDTH'(1);

  assign tag_wide      = CALC_WIDTH'(item.generation_tag);
  assign total_wide    = CALC_WIDTH'(item.total_bytes);
  assign unqueued_wide = CALC_WIDTH'(total_count - queued_count);
  assign unacked_wide  = CALC_WIDTH'(queued_count - acked_count);
  assign cur_before    = upload_active && (tag_wide == CALC_WIDTH'(gen_counter));

  // Next state for the request type.
  always_comb begin
    gen_counter_next   = gen_counter;
    total_count_next   = total_count;
    queued_count_next  = queued_count;
    acked_count_next   = acked_count;
    upload_active_next = upload_active;
    op_ok              = 1'b0;
    case (item.req_type)
      REQ_BEGIN: begin
        gen_counter_next   = gen_step;
        total_count_next   = (total_wide > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX)
                                                    : COUNT_WIDTH'(total_wide);
        queued_count_next  = '0;
        acked_count_next   = '0;
        upload_active_next = (item.total_bytes != '0);
        op_ok              = (item.total_bytes != '0);
      end
      REQ_INVALIDATE: begin
        gen_counter_next   = gen_step;
        total_count_next   = '0;
        queued_count_next  = '0;
        acked_count_next   = '0;
        upload_active_next = 1'b0;
      end
      REQ_RECORD: begin
        if (cur_before && (item.requested_bytes != '0) && (item.accepted_bytes != '0) &&
            (item.accepted_bytes <= item.requested_bytes) &&
            (CALC_WIDTH'(item.accepted_bytes) <= unqueued_wide)) begin
          queued_count_next = queued_count + COUNT_WIDTH'(CALC_WIDTH'(item.accepted_bytes));
          op_ok             = 1'b1;
        end
      end
      REQ_ACK: begin
        if (cur_before && (item.ack_bytes != '0) &&
            (CALC_WIDTH'(item.ack_bytes) <= unacked_wide)) begin
          acked_count_next = acked_count + COUNT_WIDTH'(CALC_WIDTH'(item.ack_bytes));
          op_ok            = 1'b1;
        end
      end
      default: begin
        // Query and unused codes report only.
      end
    endcase
  end

  // Response fields are taken from the state after the step.
  assign cur_after = upload_active_next &&
                     (tag_wide == CALC_WIDTH'(gen_counter_next));
  assign left_wide = CALC_WIDTH'(total_count_next - queued_count_next);

  always_comb begin
    result.op_ok       = op_ok;
    result.current_tag = PORT_WIDTH'(CALC_WIDTH'(gen_counter_next));
    result.tag_current = cur_after;
    result.chunk_size  = '0;
    if (cur_after && (max_chunk != '0)) begin
      result.chunk_size = (CALC_WIDTH'(max_chunk) < left_wide) ? max_chunk
                                                               : PORT_WIDTH'(left_wide);
    end
    result.transfer_done = cur_after && (total_count_next != '0) &&
                           (queued_count_next == total_count_next) &&
                           (acked_count_next == total_count_next);
  end

  // Tracker state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_counter   <= '0;
      total_count   <= '0;
      queued_count  <= '0;
      acked_count   <= '0;
      upload_active <= 1'b0;
    end else if (fire) begin
      gen_counter   <= gen_counter_next;
      total_count   <= total_count_next;
      queued_count  <= queued_count_next;
      acked_count   <= acked_count_next;
      upload_active <= upload_active_next;
    end
  end

endmodule

// ===== hw/rtl/upload_progress_tracker.sv =====
// ----------------------------------------------------------------------------
// Upload progress tracker
// Tracks one byte upload under a generation tag, one response per request.
// ----------------------------------------------------------------------------
//   channel  role    contents
//   req      sink    request word: type, tag, byte counts
//   rsp      source  response word: ok, tag, currency, chunk size, done
//   cfg      sink    chunk size limit, always ready
//
// A request word is registered, processed against the tracker state and
// registered again, so it appears on rsp from the response register.
// One word per cycle is sustained while rsp is ready; the state update is a single pass.
// A stall on rsp holds the response register and backs up the input register.
// Synchronous reset clears the tag, counters and active flag and sets the
// chunk size limit to 4096.
// ----------------------------------------------------------------------------
module upload_progress_tracker (
  input logic       clk,
  input logic       rst,
  upt_req_if.sink   req,
  upt_rsp_if.source rsp,
  upt_cfg_if.sink   cfg
);
  import upt_pkg::*;

  logic        s1_valid;
  req_item_t   s1_item;
  logic        out_valid;
  rsp_item_t   out_item;
  logic [2:0]  out_kind;
  logic [31:0] max_chunk;
  logic        advance;
  rsp_item_t   core_result;

  // Move the registered request on when the response register is free.
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_item.req_type        <= req.req_type;
      s1_item.generation_tag  <= req.generation_tag;
      s1_item.total_bytes     <= req.total_bytes;
      s1_item.requested_bytes <= req.requested_bytes;
      s1_item.accepted_bytes  <= req.accepted_bytes;
      s1_item.ack_bytes       <= req.ack_bytes;
    end
  end

  // Chunk size limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk <= MAX_CHUNK_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_chunk <= cfg.data;
    end
  end

  // Tracker state and response logic.
  upt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (s1_item),
    .max_chunk (max_chunk),
    .result    (core_result)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
      out_kind <= s1_item.req_type;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.op_ok         = out_item.op_ok;
  assign rsp.current_tag   = out_item.current_tag;
  assign rsp.tag_current   = out_item.tag_current;
  assign rsp.chunk_size    = out_item.chunk_size;
  assign rsp.transfer_done = out_item.transfer_done;

  // A completed upload is only reported for the current tag.
  a_done_needs_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.transfer_done |-> out_item.tag_current)
    else $error("transfer_done without tag_current");

  // A nonzero chunk is only offered for the current tag.
  a_chunk_needs_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.chunk_size != '0) |-> out_item.tag_current)
    else $error("chunk_size nonzero without tag_current");

  // Invalidate and query words never report success.
  a_ok_only_on_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.op_ok |->
      (out_kind == REQ_BEGIN) || (out_kind == REQ_RECORD) || (out_kind == REQ_ACK))
    else $error("op_ok on a word that cannot succeed");

  // A held request word stays in the input register.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("stalled request word lost");

endmodule
